/* design/dipc_pkg.sv */
// shared types, codes and constants of the display idle power controller
package dipc_pkg;

  // display power states
  localparam logic [1:0] StActive = 2'd0;
  localparam logic [1:0] StDimmed = 2'd1;
  localparam logic [1:0] StSleep  = 2'd2;

  // power profiles (code three behaves as balanced)
  localparam logic [1:0] ProfBalanced = 2'd0;
  localparam logic [1:0] ProfRuntime  = 2'd1;
  localparam logic [1:0] ProfPerf     = 2'd2;

  // configuration register indexes
  localparam logic [2:0] RegSleepTimeout = 3'd0;
  localparam logic [2:0] RegDimTimeout   = 3'd1;
  localparam logic [2:0] RegPowerProfile = 3'd2;
  localparam logic [2:0] RegActiveBright = 3'd3;
  localparam logic [2:0] RegDimmedBright = 3'd4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ThrW     = 26;  // 65535 * 1000 fits in 26 bits

  localparam logic [9:0]     MsPerS       = 10'd1000;
  localparam logic [ThrW-1:0] DimThrReset = 26'd30000;

  // cpu clock requests in MHz
  localparam logic [7:0] ClkLow  = 8'd80;
  localparam logic [7:0] ClkMid  = 8'd160;
  localparam logic [7:0] ClkHigh = 8'd240;

  // loop delays in ms
  localparam logic [7:0] DelayFast       = 8'd5;
  localparam logic [7:0] DelayDimBal     = 8'd25;
  localparam logic [7:0] DelayDimRuntime = 8'd50;
  localparam logic [7:0] DelaySleepBal   = 8'd80;
  localparam logic [7:0] DelaySleepRt    = 8'd140;

  // foreground refresh intervals in ms
  localparam logic [9:0] RefreshNone = 10'd0;
  localparam logic [9:0] RefreshPerf = 10'd100;
  localparam logic [9:0] RefreshSlow = 10'd1000;

  // configuration as seen by the event logic, timeouts already in ms
  typedef struct packed {
    logic [ThrW-1:0] sleep_thr_ms;
    logic [ThrW-1:0] dim_thr_ms;
    logic [1:0]      profile;
    logic [7:0]      active_bright;
    logic [7:0]      dimmed_bright;
  } cfg_t;

  // controller state carried between events
  typedef struct packed {
    logic [1:0]  disp_state;
    logic [31:0] last_act_ms;
    logic [7:0]  cur_clk;
  } ctl_state_t;

  // one input event
  typedef struct packed {
    logic        func;
    logic [31:0] now_ms;
    logic        app_demanding;
  } evt_t;

  // one result
  typedef struct packed {
    logic [1:0] power_state;
    logic       display_on;
    logic [7:0] brightness;
    logic       entered_sleep;
    logic       woke_up;
    logic [7:0] cpu_mhz;
    logic       cpu_changed;
    logic [7:0] loop_delay_ms;
    logic [9:0] refresh_interval_ms;
  } res_t;

endpackage

/* design/display_idle_power_controller_core.sv */
// top level: input register, event logic, state and result register
// Display idle power controller: each event (user activity or periodic tick with a
// millisecond timestamp) passes through an input register and the event logic
// into the result register, so one event is taken per clock while the output is
// not stalled; each result is held on the outputs by the result register until
// it is taken while the output is not stalled. The
// controller state (display state, last activity time, cpu clock) is updated as
// the event moves into the result register, so back-to-back events see each other.
// Timeouts are converted to milliseconds when written; configuration must only be
// written while no event is in flight.
module display_idle_power_controller_core import dipc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic [31:0]         now_ms_i,
  input  logic                app_demanding_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          power_state_o,
  output logic                display_on_o,
  output logic [7:0]          brightness_o,
  output logic                entered_sleep_o,
  output logic                woke_up_o,
  output logic [7:0]          cpu_mhz_o,
  output logic                cpu_changed_o,
  output logic [7:0]          loop_delay_ms_o,
  output logic [9:0]          refresh_interval_ms_o
);

  cfg_t       cfg;
  evt_t       evt_q;
  logic       evt_vld_q;
  ctl_state_t st_q;
  ctl_state_t st_d;
  res_t       res_d;
  res_t       res_q;
  logic       res_vld_q;
  logic       res_free;
  logic       advance;

  dipc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dipc_step u_step (
    .cfg_i (cfg),
    .st_i  (st_q),
    .evt_i (evt_q),
    .st_o  (st_d),
    .res_o (res_d)
  );

  // pipeline flow control
  assign res_free   = !res_vld_q || !out_stall_i;
  assign advance    = evt_vld_q && res_free;
  assign in_stall_o = evt_vld_q && !res_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      evt_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      evt_q.func          <= func_i;
      evt_q.now_ms        <= now_ms_i;
      evt_q.app_demanding <= app_demanding_i;
    end
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.disp_state  <= StActive;
      st_q.last_act_ms <= '0;
      st_q.cur_clk     <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= evt_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o           = res_vld_q;
  assign power_state_o         = res_q.power_state;
  assign display_on_o          = res_q.display_on;
  assign brightness_o          = res_q.brightness;
  assign entered_sleep_o       = res_q.entered_sleep;
  assign woke_up_o             = res_q.woke_up;
  assign cpu_mhz_o             = res_q.cpu_mhz;
  assign cpu_changed_o         = res_q.cpu_changed;
  assign loop_delay_ms_o       = res_q.loop_delay_ms;
  assign refresh_interval_ms_o = res_q.refresh_interval_ms;

endmodule

/* design/dipc_cfg.sv */
// configuration registers, timeouts converted to milliseconds on write
module dipc_cfg import dipc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t            cfg_q;
  logic [ThrW-1:0] thr_ms;

  // seconds to milliseconds, constant multiply
  assign thr_ms = ThrW'({10'b0, cfg_wdata_i} * {16'b0, MsPerS});

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sleep_thr_ms  <= '0;
      cfg_q.dim_thr_ms    <= DimThrReset;
      cfg_q.profile       <= ProfBalanced;
      cfg_q.active_bright <= 8'd128;
      cfg_q.dimmed_bright <= 8'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSleepTimeout: cfg_q.sleep_thr_ms  <= thr_ms;
        RegDimTimeout:   cfg_q.dim_thr_ms    <= thr_ms;
        RegPowerProfile: cfg_q.profile       <= cfg_wdata_i[1:0];
        RegActiveBright: cfg_q.active_bright <= cfg_wdata_i[7:0];
        RegDimmedBright: cfg_q.dimmed_bright <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/dipc_step.sv */
// event logic: next controller state and the result for one event
module dipc_step import dipc_pkg::*; (
  input  cfg_t       cfg_i,
  input  ctl_state_t st_i,
  input  evt_t       evt_i,
  output ctl_state_t st_o,
  output res_t       res_o
);

  logic [31:0] idle_ms;
  logic        perf_like;
  logic        sleep_go;
  logic        dim_go;
  logic [1:0]  nxt_state;
  logic        req_en;
  logic [7:0]  req_clk;
  logic        entered;
  logic        woke;

  assign idle_ms   = evt_i.now_ms - st_i.last_act_ms;
  assign perf_like = (cfg_i.profile == ProfPerf) || evt_i.app_demanding;
  assign sleep_go  = (cfg_i.sleep_thr_ms != '0) && (st_i.disp_state != StSleep) &&
                     (idle_ms >= {6'b0, cfg_i.sleep_thr_ms});
  assign dim_go    = (st_i.disp_state == StActive) && (idle_ms >= {6'b0, cfg_i.dim_thr_ms});

  // state transition and clock request
  always_comb begin
    nxt_state = st_i.disp_state;
    req_en    = 1'b0;
    req_clk   = ClkLow;
    entered   = 1'b0;
    woke      = 1'b0;
    if (!evt_i.func) begin
      // user activity
      if (st_i.disp_state == StSleep) begin
        nxt_state = StActive;
        woke      = 1'b1;
        req_en    = 1'b1;
        if (cfg_i.profile == ProfPerf) begin
          req_clk = ClkHigh;
        end else if (cfg_i.profile == ProfRuntime) begin
          req_clk = ClkLow;
        end else begin
          req_clk = ClkMid;
        end
      end else if (st_i.disp_state == StDimmed) begin
        nxt_state = StActive;
      end
    end else begin
      // periodic tick
      req_en = 1'b1;
      if (sleep_go) begin
        nxt_state = StSleep;
        entered   = 1'b1;
        req_clk   = perf_like ? ClkHigh : ClkLow;
      end else begin
        if (dim_go) begin
          nxt_state = StDimmed;
        end
        if (perf_like) begin
          req_clk = ClkHigh;
        end else if (nxt_state == StActive) begin
          req_clk = (cfg_i.profile == ProfRuntime) ? ClkLow : ClkMid;
        end else begin
          req_clk = ClkLow;
        end
      end
    end
  end

  // next state
  always_comb begin
    st_o             = st_i;
    st_o.disp_state  = nxt_state;
    if (!evt_i.func) begin
      st_o.last_act_ms = evt_i.now_ms;
    end
    if (req_en) begin
      st_o.cur_clk = req_clk;
    end
  end

  // result fields
  always_comb begin
    res_o.power_state   = nxt_state;
    res_o.display_on    = (nxt_state != StSleep);
    res_o.entered_sleep = entered;
    res_o.woke_up       = woke;
    res_o.cpu_mhz       = req_en ? req_clk : st_i.cur_clk;
    res_o.cpu_changed   = req_en && (req_clk != st_i.cur_clk);
    if (nxt_state == StSleep) begin
      res_o.brightness          = 8'd0;
      res_o.refresh_interval_ms = RefreshNone;
      if (perf_like) begin
        res_o.loop_delay_ms = DelayFast;
      end else if (cfg_i.profile == ProfRuntime) begin
        res_o.loop_delay_ms = DelaySleepRt;
      end else begin
        res_o.loop_delay_ms = DelaySleepBal;
      end
    end else if (nxt_state == StDimmed) begin
      res_o.brightness          = cfg_i.dimmed_bright;
      res_o.refresh_interval_ms = perf_like ? RefreshPerf : RefreshSlow;
      if (perf_like) begin
        res_o.loop_delay_ms = DelayFast;
      end else if (cfg_i.profile == ProfRuntime) begin
        res_o.loop_delay_ms = DelayDimRuntime;
      end else begin
        res_o.loop_delay_ms = DelayDimBal;
      end
    end else begin
      res_o.brightness          = cfg_i.active_bright;
      res_o.refresh_interval_ms = RefreshNone;
      res_o.loop_delay_ms       = DelayFast;
    end
  end

endmodule
